// ===== src/assert_macros.svh =====
// Assertion macros used by the RTL core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/pidspc_pkg.sv =====
// Types and constants of the PID speed/position controller.
package pidspc_pkg;

	localparam int GAIN_W      = 16;
	localparam int LIMIT_W     = 15;
	localparam int DEADBAND_W  = 16;
	localparam int MAX_ERR_W   = 17;
	localparam int PERIOD_W    = 16;
	localparam int CFG_INDEX_W = 4;
	localparam int CFG_DATA_W  = 17;
	localparam int STATUS_W    = 2;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'h7fff;

	// Configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_KP             = 4'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_KI             = 4'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_KD             = 4'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_OUTPUT_LIMIT   = 4'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_INTEGRAL_LIMIT = 4'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_DEADBAND       = 4'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_MAX_ERROR      = 4'd6;
	localparam logic [CFG_INDEX_W-1:0] REG_WRAP_PERIOD    = 4'd7;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_NORMAL    = 2'd0,
		STATUS_MAX_ERROR = 2'd1,
		STATUS_DEADBAND  = 2'd2
	} status_t;

endpackage

// ===== src/pid_speed_position_controller_core.sv =====
// PID controller core: wrap handling, error cut-off, deadband, clamped P/I/D sum.
// A result is registered through a 4-stage pipeline after its request is accepted (stages:
// input/error, status and history, gain multipliers, integral and output clamp).
// Throughput: one request per cycle; the pipeline only stalls when the output register
// is full and not taken. Stages with bubbles keep accepting while a result waits.
// Reset (arst_n low, asynchronous): pipeline emptied, history and integral cleared,
// gains zero, limits at full scale, deadband, max_error and wrap_period disabled.
`include "assert_macros.svh"

module pid_speed_position_controller_core #(
	parameter int DATA_WIDTH     = 16,
	parameter int GAIN_FRAC_BITS = 8
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_write,
	input  logic [pidspc_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [pidspc_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [DATA_WIDTH-1:0]          measured,
	input  logic signed [DATA_WIDTH-1:0]          target,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [DATA_WIDTH-1:0]          drive,
	output logic [pidspc_pkg::STATUS_W-1:0]       status
);

	localparam int EW  = ((DATA_WIDTH > 16) ? DATA_WIDTH : 16) + 3; // error width
	localparam int DDW = EW + 2;                                    // second difference
	localparam int GW  = pidspc_pkg::GAIN_W + 1;                    // gain as signed
	localparam int PW  = EW + GW;
	localparam int DPW = DDW + GW;
	localparam int SW  = DPW + 2;                                   // term sum width
	localparam int IW  = pidspc_pkg::LIMIT_W + 1;                   // integral width

	// configuration registers
	logic [pidspc_pkg::GAIN_W-1:0]     kp_q, ki_q, kd_q;
	logic [pidspc_pkg::LIMIT_W-1:0]    output_limit_q, integral_limit_q;
	logic [pidspc_pkg::DEADBAND_W-1:0] deadband_q;
	logic [pidspc_pkg::MAX_ERR_W-1:0]  max_error_q;
	logic [pidspc_pkg::PERIOD_W-1:0]   wrap_period_q;

	// pipeline
	logic                      valid_s1, valid_s2, valid_s3, out_valid_q;
	logic signed [EW-1:0]      err_s1, err_s2;
	logic signed [DDW-1:0]     dd_s2;
	pidspc_pkg::status_t       status_s2, status_s3, status_q;
	logic signed [PW-1:0]      p_prod_s3, i_prod_s3;
	logic signed [DPW-1:0]     d_prod_s3;
	logic signed [DATA_WIDTH-1:0] drive_q;

	// controller state
	logic signed [EW-1:0]      err_last_q, err_prev_q;
	logic signed [IW-1:0]      integral_q;

	logic adv_out, adv3, adv2, accept;

	// ---------------- flow control ----------------
	assign adv_out  = valid_s3 && (!out_valid_q || out_ready);
	assign adv3     = valid_s2 && (!valid_s3 || adv_out);
	assign adv2     = valid_s1 && (!valid_s2 || adv3);
	assign in_ready = !valid_s1 || adv2;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			valid_s1    <= accept || (valid_s1 && !adv2);
			valid_s2    <= adv2 || (valid_s2 && !adv3);
			valid_s3    <= adv3 || (valid_s3 && !adv_out);
			out_valid_q <= adv_out || (out_valid_q && !out_ready);
		end
	end

	// ---------------- configuration ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q             <= '0;
			ki_q             <= '0;
			kd_q             <= '0;
			output_limit_q   <= pidspc_pkg::LIMIT_RESET;
			integral_limit_q <= pidspc_pkg::LIMIT_RESET;
			deadband_q       <= '0;
			max_error_q      <= '0;
			wrap_period_q    <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				pidspc_pkg::REG_KP: begin
					kp_q <= cfg_data[pidspc_pkg::GAIN_W-1:0];
				end
				pidspc_pkg::REG_KI: begin
					ki_q <= cfg_data[pidspc_pkg::GAIN_W-1:0];
				end
				pidspc_pkg::REG_KD: begin
					kd_q <= cfg_data[pidspc_pkg::GAIN_W-1:0];
				end
				pidspc_pkg::REG_OUTPUT_LIMIT: begin
					output_limit_q <= cfg_data[pidspc_pkg::LIMIT_W-1:0];
				end
				pidspc_pkg::REG_INTEGRAL_LIMIT: begin
					integral_limit_q <= cfg_data[pidspc_pkg::LIMIT_W-1:0];
				end
				pidspc_pkg::REG_DEADBAND: begin
					deadband_q <= cfg_data[pidspc_pkg::DEADBAND_W-1:0];
				end
				pidspc_pkg::REG_MAX_ERROR: begin
					max_error_q <= cfg_data[pidspc_pkg::MAX_ERR_W-1:0];
				end
				pidspc_pkg::REG_WRAP_PERIOD: begin
					wrap_period_q <= cfg_data[pidspc_pkg::PERIOD_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// ---------------- stage 1: wrap adjust and error ----------------
	logic signed [EW-1:0] m_x, t_x, per_x, d_mt, d_tm, m_adj;

	assign m_x   = {{(EW-DATA_WIDTH){measured[DATA_WIDTH-1]}}, measured};
	assign t_x   = {{(EW-DATA_WIDTH){target[DATA_WIDTH-1]}}, target};
	assign per_x = $signed({{(EW-pidspc_pkg::PERIOD_W){1'b0}}, wrap_period_q});
	assign d_mt  = m_x - t_x;
	assign d_tm  = t_x - m_x;

	// measurement moves by one period only when it sits on the far side of the seam
	always_comb begin
		m_adj = m_x;
		if (wrap_period_q != '0) begin
			if ((d_mt <<< 1) > per_x) begin
				if ((m_x <<< 1) > per_x) begin
					m_adj = m_x - per_x;
				end
			end else if ((d_tm <<< 1) > per_x) begin
				if ((m_x <<< 1) < per_x) begin
					m_adj = m_x + per_x;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			err_s1 <= t_x - m_adj;
		end
	end

	// ---------------- stage 2: status and error history ----------------
	logic [EW-1:0]         err_mag;
	logic                  too_large, in_band;
	pidspc_pkg::status_t   status_d;
	logic signed [DDW-1:0] dd_d;

	assign err_mag   = err_s1[EW-1] ? EW'(-err_s1) : EW'(err_s1);
	assign too_large = (max_error_q != '0) &&
		(err_mag > {{(EW-pidspc_pkg::MAX_ERR_W){1'b0}}, max_error_q});
	assign in_band   = (deadband_q != '0) &&
		(err_mag < {{(EW-pidspc_pkg::DEADBAND_W){1'b0}}, deadband_q});
	assign dd_d      = DDW'(err_s1) - (DDW'(err_last_q) <<< 1) + DDW'(err_prev_q);

	always_comb begin
		if (too_large) begin
			status_d = pidspc_pkg::STATUS_MAX_ERROR;
		end else if (in_band) begin
			status_d = pidspc_pkg::STATUS_DEADBAND;
		end else begin
			status_d = pidspc_pkg::STATUS_NORMAL;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			err_s2    <= err_s1;
			dd_s2     <= dd_d;
			status_s2 <= status_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_last_q <= '0;
			err_prev_q <= '0;
		end else if (adv2 && (status_d == pidspc_pkg::STATUS_NORMAL)) begin
			err_prev_q <= err_last_q;
			err_last_q <= err_s1;
		end
	end

	// ---------------- stage 3: gain products ----------------
	logic signed [GW-1:0] kp_s, ki_s, kd_s;

	assign kp_s = $signed({1'b0, kp_q});
	assign ki_s = $signed({1'b0, ki_q});
	assign kd_s = $signed({1'b0, kd_q});

	always_ff @(posedge clk) begin
		if (adv3) begin
			p_prod_s3 <= kp_s * err_s2;
			i_prod_s3 <= ki_s * err_s2;
			d_prod_s3 <= kd_s * dd_s2;
			status_s3 <= status_s2;
		end
	end

	// ---------------- output stage: integral and output clamp ----------------
	logic signed [SW-1:0] p_term, i_term, d_term, i_raw, i_new, ilim_p, ilim_n;
	logic signed [SW-1:0] sum, sum_clamped, olim_p, olim_n;
	logic signed [DATA_WIDTH-1:0] drive_d;

	// arithmetic shift drops fraction bits, rounding toward minus infinity
	assign p_term = SW'(p_prod_s3 >>> GAIN_FRAC_BITS);
	assign i_term = SW'(i_prod_s3 >>> GAIN_FRAC_BITS);
	assign d_term = SW'(d_prod_s3 >>> GAIN_FRAC_BITS);
	assign ilim_p = $signed({{(SW-pidspc_pkg::LIMIT_W){1'b0}}, integral_limit_q});
	assign ilim_n = -ilim_p;
	assign olim_p = $signed({{(SW-pidspc_pkg::LIMIT_W){1'b0}}, output_limit_q});
	assign olim_n = -olim_p;
	assign i_raw  = SW'(integral_q) + i_term;

	always_comb begin
		if (i_raw > ilim_p) begin
			i_new = ilim_p;
		end else if (i_raw < ilim_n) begin
			i_new = ilim_n;
		end else begin
			i_new = i_raw;
		end
		sum = p_term + i_new + d_term;
		if (sum > olim_p) begin
			sum_clamped = olim_p;
		end else if (sum < olim_n) begin
			sum_clamped = olim_n;
		end else begin
			sum_clamped = sum;
		end
		if (status_s3 == pidspc_pkg::STATUS_NORMAL) begin
			drive_d = sum_clamped[DATA_WIDTH-1:0];
		end else begin
			drive_d = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_out) begin
			drive_q  <= drive_d;
			status_q <= status_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integral_q <= '0;
		end else if (adv_out) begin
			case (status_s3)
				pidspc_pkg::STATUS_NORMAL: begin
					integral_q <= i_new[IW-1:0];
				end
				pidspc_pkg::STATUS_DEADBAND: begin
					integral_q <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign drive     = drive_q;
	assign status    = status_q;

	// ---------------- assertions ----------------
	`ASSERT_NOW(a_zero_drive_off_normal, clk, arst_n,
		out_valid_q && (status_q != pidspc_pkg::STATUS_NORMAL), drive_q == '0, "drive not zero outside normal status")
	`ASSERT_NEXT(a_integral_held, clk, arst_n,
		!adv_out, $stable(integral_q), "integral changed without a result")
	`ASSERT_NEXT(a_deadband_clears, clk, arst_n,
		adv_out && (status_s3 == pidspc_pkg::STATUS_DEADBAND), integral_q == '0, "integral not cleared in deadband")
	`ASSERT_NEXT(a_history_held, clk, arst_n,
		!adv2, $stable(err_last_q) && $stable(err_prev_q), "error history changed without a request")

endmodule
